// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int RES_W = 64;
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHECK,
        ST_GCD_START,
        ST_GCD_RUN,
        ST_DIVN_START,
        ST_DIVN_RUN,
        ST_DIVD_START,
        ST_DIVD_RUN,
        ST_DONE
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic div_start;
        logic div_step;
        logic gcd_sel;
        logic gcd_swap;
        logic save_qn;
        logic save_qd;
        logic out_zero;
        logic out_dz;
        logic out_red;
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic is_dz;
        logic n_zero;
        logic y_zero;
        logic div_done;
    } t_status;

endpackage

// ===== rtl/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit.
// Divide-by-zero and zero-numerator results skip the reduction; otherwise
// the gcd is found by Euclid steps and both parts are divided by it, all on one
// shared 1-bit-per-cycle restoring divider. One item in flight at a time.
// A new item is taken only after the previous result beat has been accepted.
// Reset (synchronous, active low) returns the controller to idle, no result.
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_action,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic [OPERAND_WIDTH-2:0]        i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic [OPERAND_WIDTH-2:0]        i_b_den,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [rau_pkg::RES_W-1:0] o_res_num,
    output logic signed [rau_pkg::RES_W-1:0] o_res_den,
    output logic                            o_div_zero
);
    rau_pkg::t_cmd    cmd;
    rau_pkg::t_status status;

    rau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_action   (i_action),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_div_zero (o_div_zero)
    );
endmodule

// ===== rtl/rau_datapath.sv =====
// Datapath: cross products, shared restoring divider and result registers.
module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic [1:0]                 i_action,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic [OPERAND_WIDTH-2:0]   i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic [OPERAND_WIDTH-2:0]   i_b_den,
    input  rau_pkg::t_cmd              i_cmd,
    output rau_pkg::t_status           o_status,
    output logic signed [rau_pkg::RES_W-1:0] o_res_num,
    output logic signed [rau_pkg::RES_W-1:0] o_res_den,
    output logic                       o_div_zero
);
    localparam int W  = rau_pkg::RES_W;
    localparam int PW = 2 * OPERAND_WIDTH;

    logic [1:0]          r_act;
    // Operands are kept at their own width; denominators get a zero sign bit.
    logic signed [OPERAND_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [W-1:0] r_p1, r_p2, r_d;
    logic signed [W-1:0] r_n;
    logic [W-1:0]        r_x, r_y, r_qn;
    logic                r_neg;
    // Divider state: remainder, quotient/dividend shift, divisor, bit count.
    logic [W:0]          r_rem;
    logic [W-1:0]        r_quo, r_dvs;
    logic [rau_pkg::CNT_W-1:0] r_cnt;
    logic signed [W-1:0] r_res_num, r_res_den;
    logic                r_dz;

    logic [W:0]   n_rem_sh;
    logic [W:0]   n_rem_sub;
    logic [W-1:0] mag_n, mag_d;
    logic signed [PW-1:0] mul_an_bd, mul_ad_bn, mul_an_bn, mul_ad_bd;

    assign mag_n = r_n[W-1] ? W'(-r_n) : W'(r_n);
    assign mag_d = r_d[W-1] ? W'(-r_d) : W'(r_d);

    assign n_rem_sh  = {r_rem[W-1:0], r_quo[W-1]};
    assign n_rem_sub = n_rem_sh - {1'b0, r_dvs};

    // Operand-width cross products.
    assign mul_an_bd = PW'(r_an) * PW'(r_bd);
    assign mul_ad_bn = PW'(r_ad) * PW'(r_bn);
    assign mul_an_bn = PW'(r_an) * PW'(r_bn);
    assign mul_ad_bd = PW'(r_ad) * PW'(r_bd);

    // Operand capture, products, sum and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_an  <= i_a_num;
            r_ad  <= $signed({1'b0, i_a_den});
            r_bn  <= i_b_num;
            r_bd  <= $signed({1'b0, i_b_den});
        end
        if (i_cmd.mul) begin
            case (rau_pkg::t_action'(r_act))
                rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
                    r_p1 <= W'(mul_an_bd);
                    r_p2 <= W'(mul_ad_bn);
                    r_d  <= W'(mul_ad_bd);
                end
                rau_pkg::ACT_MUL: begin
                    r_p1 <= W'(mul_an_bn);
                    r_p2 <= '0;
                    r_d  <= W'(mul_ad_bd);
                end
                default: begin
                    r_p1 <= W'(mul_an_bd);
                    r_p2 <= '0;
                    r_d  <= W'(mul_ad_bn);
                end
            endcase
        end
        if (i_cmd.sum) begin
            if (rau_pkg::t_action'(r_act) == rau_pkg::ACT_SUB) begin
                r_n <= r_p1 - r_p2;
            end else begin
                r_n <= r_p1 + r_p2;
            end
        end
        // Euclid: x, y start as magnitudes; each step x <= y, y <= x mod y.
        // When y reaches zero, x holds the gcd.
        if (i_cmd.gcd_sel) begin
            r_x   <= mag_n;
            r_y   <= mag_d;
            r_neg <= r_n[W-1] ^ r_d[W-1];
        end
        if (i_cmd.gcd_swap) begin
            r_x <= r_y;
            r_y <= r_rem[W-1:0];
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_cnt <= '0;
            if (i_cmd.save_qn) begin
                r_quo <= mag_n;
                r_dvs <= r_x;
            end else if (i_cmd.save_qd) begin
                r_quo <= mag_d;
                r_dvs <= r_x;
            end else begin
                r_quo <= r_x;
                r_dvs <= r_y;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!n_rem_sub[W]) begin
                r_rem <= n_rem_sub;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
        if (i_cmd.save_qn && !i_cmd.div_start) begin
            r_qn <= r_quo;
        end
        // Output register.
        if (i_cmd.out_dz) begin
            r_res_num <= '0;
            r_res_den <= W'(1);
            r_dz      <= 1'b1;
        end else if (i_cmd.out_zero) begin
            r_res_num <= '0;
            r_res_den <= r_d;
            r_dz      <= 1'b0;
        end else if (i_cmd.out_red) begin
            r_res_num <= r_neg ? W'(-r_qn) : r_qn;
            r_res_den <= r_quo;
            r_dz      <= 1'b0;
        end
    end

    assign o_status.is_dz    = (rau_pkg::t_action'(r_act) == rau_pkg::ACT_DIV) && (r_bn == '0);
    assign o_status.n_zero   = (r_n == '0);
    assign o_status.y_zero   = (r_y == '0);
    assign o_status.div_done = (r_cnt == rau_pkg::CNT_W'(W));

    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_div_zero = r_dz;
endmodule

// ===== rtl/rau_ctrl.sv =====
// Controller: sequences products, gcd and the two reducing divisions.
module rau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  rau_pkg::t_status i_status,
    output rau_pkg::t_cmd    o_cmd
);
    rau_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_IDLE:   if (i_valid) n_state = rau_pkg::ST_MUL;
            rau_pkg::ST_MUL:    n_state = rau_pkg::ST_SUM;
            rau_pkg::ST_SUM:    n_state = rau_pkg::ST_CHECK;
            rau_pkg::ST_CHECK: begin
                if (i_status.is_dz || i_status.n_zero) begin
                    n_state = rau_pkg::ST_DONE;
                end else begin
                    n_state = rau_pkg::ST_GCD_START;
                end
            end
            rau_pkg::ST_GCD_START: begin
                if (i_status.y_zero) begin
                    n_state = rau_pkg::ST_DIVN_START;
                end else begin
                    n_state = rau_pkg::ST_GCD_RUN;
                end
            end
            rau_pkg::ST_GCD_RUN: if (i_status.div_done) n_state = rau_pkg::ST_GCD_START;
            rau_pkg::ST_DIVN_START: n_state = rau_pkg::ST_DIVN_RUN;
            rau_pkg::ST_DIVN_RUN:   if (i_status.div_done) n_state = rau_pkg::ST_DIVD_START;
            rau_pkg::ST_DIVD_START: n_state = rau_pkg::ST_DIVD_RUN;
            rau_pkg::ST_DIVD_RUN:   if (i_status.div_done) n_state = rau_pkg::ST_DONE;
            rau_pkg::ST_DONE:       if (!i_stall) n_state = rau_pkg::ST_IDLE;
            default:                n_state = rau_pkg::ST_IDLE;
        endcase
    end

    // Outputs. The gcd loop enters with x, y loaded once from the magnitudes.
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            rau_pkg::ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            rau_pkg::ST_MUL: o_cmd.mul = 1'b1;
            rau_pkg::ST_SUM: o_cmd.sum = 1'b1;
            rau_pkg::ST_CHECK: begin
                o_cmd.gcd_sel  = 1'b1;
                o_cmd.out_dz   = i_status.is_dz;
                o_cmd.out_zero = !i_status.is_dz && i_status.n_zero;
            end
            rau_pkg::ST_GCD_START: begin
                o_cmd.div_start = !i_status.y_zero;
            end
            rau_pkg::ST_GCD_RUN: begin
                o_cmd.div_step = !i_status.div_done;
                o_cmd.gcd_swap = i_status.div_done;
            end
            rau_pkg::ST_DIVN_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.save_qn   = 1'b1;
            end
            rau_pkg::ST_DIVN_RUN: begin
                o_cmd.div_step = !i_status.div_done;
                o_cmd.save_qn  = i_status.div_done;
            end
            rau_pkg::ST_DIVD_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.save_qd   = 1'b1;
            end
            rau_pkg::ST_DIVD_RUN: begin
                o_cmd.div_step = !i_status.div_done;
                o_cmd.out_red  = i_status.div_done;
            end
            rau_pkg::ST_DONE: o_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_res_num,
    input logic [63:0] o_res_den,
    input logic        o_div_zero
);
    // A held result beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_num) && $stable(o_res_den))
        else $error("result changed while stalled");

    // No input is taken while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted with result pending");

    // A divide-by-zero result is 0 over 1.
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_num == 64'd0 && o_res_den == 64'd1)
        else $error("bad divide-by-zero result");

    // An accepted item cannot yield a result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("result too early");
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_res_num  (o_res_num),
    .o_res_den  (o_res_den),
    .o_div_zero (o_div_zero)
);

// ===== tb/rational_arith_unit_tb.sv =====
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps

module rational_arith_unit_tb;

    localparam int OW        = rau_pkg::OPERAND_WIDTH_DEF;
    localparam int RW        = rau_pkg::RES_W;
    localparam int WDOG_MAX  = 30000;
    localparam int HOLD_LEN  = 400;
    localparam int N_PHASE   = 4;
    localparam int PHASE_LEN = 475;
    localparam int DRAIN_GAP = 300;

    localparam logic signed [OW-1:0] NMAX = 32'sh7fffffff;
    localparam logic signed [OW-1:0] NMIN = 32'sh80000000;
    localparam logic [OW-2:0]        DMAX = 31'h7fffffff;

    // One reduced fraction as the block should deliver it.
    typedef struct {
        logic signed [RW-1:0] num;
        logic signed [RW-1:0] den;
        logic                 dz;
    } t_fraction;

    // One row of the directed stimulus table.
    typedef struct {
        rau_pkg::t_action        act;
        logic signed [OW-1:0]    an;
        logic [OW-2:0]           ad;
        logic signed [OW-1:0]    bn;
        logic [OW-2:0]           bd;
        bit                      typed;
        t_fraction               want;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [1:0]               i_action;
    logic signed [OW-1:0]     i_a_num;
    logic [OW-2:0]            i_a_den;
    logic signed [OW-1:0]     i_b_num;
    logic [OW-2:0]            i_b_den;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [RW-1:0]     o_res_num;
    logic signed [RW-1:0]     o_res_den;
    logic                     o_div_zero;

    t_fraction pending_q[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_req = 0;
    bit        in_beat;
    bit        out_beat;

    rational_arith_unit #(.OPERAND_WIDTH(OW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .o_valid(o_valid), .i_stall(i_stall),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_div_zero(o_div_zero)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    assign in_beat  = i_valid && !o_stall;
    assign out_beat = o_valid && !i_stall;

    // Greatest common divisor of two magnitudes.
    function automatic logic [RW-1:0] gcd_mag(logic [RW-1:0] x, logic [RW-1:0] y);
        logic [RW-1:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Expected reduced fraction for one operation.
    function automatic t_fraction reduce_fraction(rau_pkg::t_action act,
            logic signed [OW-1:0] an, logic [OW-2:0] ad, logic signed [OW-1:0] bn,
            logic [OW-2:0] bd);
        t_fraction        r;
        longint           n;
        longint           d;
        longint           san;
        longint           sbn;
        longint           sad;
        longint           sbd;
        logic [RW-1:0]    mn;
        logic [RW-1:0]    md;
        logic [RW-1:0]    g;
        san = an;
        sbn = bn;
        sad = longint'({1'b0, ad});
        sbd = longint'({1'b0, bd});
        r.dz = 1'b0;
        if (act == rau_pkg::ACT_DIV && bn == 0) begin
            r.num = 0;
            r.den = 1;
            r.dz  = 1'b1;
            return r;
        end
        case (act)
            rau_pkg::ACT_ADD: begin n = san * sbd + sad * sbn; d = sad * sbd; end
            rau_pkg::ACT_SUB: begin n = san * sbd - sad * sbn; d = sad * sbd; end
            rau_pkg::ACT_MUL: begin n = san * sbn;             d = sad * sbd; end
            default:          begin n = san * sbd;             d = sad * sbn; end
        endcase
        if (n == 0) begin
            r.num = 0;
            r.den = d;
            return r;
        end
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        g  = gcd_mag(mn, md);
        r.num = ((n < 0) != (d < 0)) ? -(mn / g) : (mn / g);
        r.den = md / g;
        return r;
    endfunction

    // Random operand: mostly small values keep the Euclid loop short.
    function automatic logic signed [OW-1:0] rand_num();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 6) return OW'($urandom);
        if (sel < 10) return '0;
        return OW'($signed($urandom_range(0, 126)) - 63);
    endfunction

    function automatic logic [OW-2:0] rand_den();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 6) return (OW-1)'($urandom);
        if (sel < 7) return '0;
        return (OW-1)'($urandom_range(1, 63));
    endfunction

    // Offer one beat, idling first at random, and record what it should produce.
    task automatic send_item(rau_pkg::t_action act, logic signed [OW-1:0] an,
            logic [OW-2:0] ad, logic signed [OW-1:0] bn, logic [OW-2:0] bd, bit typed,
            t_fraction want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_a_num  <= an;
        i_a_den  <= ad;
        i_b_num  <= bn;
        i_b_den  <= bd;
        do @(posedge i_clk); while (!in_beat);
        pending_q.push_back(typed ? want : reduce_fraction(act, an, ad, bn, bd));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_row mk(rau_pkg::t_action act, logic signed [OW-1:0] an,
            logic [OW-2:0] ad, logic signed [OW-1:0] bn, logic [OW-2:0] bd,
            bit typed = 0, longint en = 0, longint ed = 0, bit edz = 0);
        t_row r;
        r.act = act; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd; r.typed = typed;
        r.want.num = en; r.want.den = ed; r.want.dz = edz;
        return r;
    endfunction

    // Stimulus: directed table, then random phases with different idling.
    initial begin
        t_row                 rows[$];
        t_fraction            none;
        rau_pkg::t_action     act;
        logic signed [OW-1:0] bn;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_action <= rau_pkg::ACT_ADD;
        i_a_num  <= '0;
        i_a_den  <= (OW-1)'(1);
        i_b_num  <= '0;
        i_b_den  <= (OW-1)'(1);
        none = '{default: 0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(mk(rau_pkg::ACT_ADD, 0, 1, 0, 1, 1, 0, 1, 0));
        rows.push_back(mk(rau_pkg::ACT_DIV, 5, 3, 0, 7, 1, 0, 1, 1));
        rows.push_back(mk(rau_pkg::ACT_DIV, 7, 3, 0, 0, 1, 0, 1, 1));
        rows.push_back(mk(rau_pkg::ACT_DIV, 0, 3, -4, 5, 1, 0, -12, 0));
        rows.push_back(mk(rau_pkg::ACT_ADD, 5, 0, 3, 7, 1, 1, 0, 0));
        rows.push_back(mk(rau_pkg::ACT_MUL, -5, 0, 3, 2, 1, -1, 0, 0));
        rows.push_back(mk(rau_pkg::ACT_SUB, 3, 4, 3, 4, 1, 0, 16, 0));
        rows.push_back(mk(rau_pkg::ACT_MUL, 1, 2, 1, 3, 1, 1, 6, 0));
        rows.push_back(mk(rau_pkg::ACT_ADD, 1, 2, 1, 3));
        rows.push_back(mk(rau_pkg::ACT_SUB, 1, 2, 1, 3));
        rows.push_back(mk(rau_pkg::ACT_DIV, -2, 3, 4, 9));
        rows.push_back(mk(rau_pkg::ACT_DIV, 2, 3, -4, 9));
        rows.push_back(mk(rau_pkg::ACT_MUL, NMAX, 1, NMAX, 1));
        rows.push_back(mk(rau_pkg::ACT_MUL, NMIN, 1, NMIN, 1));
        rows.push_back(mk(rau_pkg::ACT_ADD, NMIN, DMAX, NMIN, DMAX));
        rows.push_back(mk(rau_pkg::ACT_ADD, NMIN, 1, NMIN, 1));
        rows.push_back(mk(rau_pkg::ACT_SUB, NMAX, DMAX, NMIN, 1));
        rows.push_back(mk(rau_pkg::ACT_DIV, NMIN, DMAX, NMAX, DMAX));
        rows.push_back(mk(rau_pkg::ACT_DIV, NMAX, 1, NMIN, 1));
        rows.push_back(mk(rau_pkg::ACT_ADD, NMAX, DMAX, -1, 1));
        rows.push_back(mk(rau_pkg::ACT_MUL, 0, DMAX, NMIN, DMAX));
        rows.push_back(mk(rau_pkg::ACT_SUB, -1, 2147483646, 1, 2147483645));
        foreach (rows[k])
            send_item(rows[k].act, rows[k].an, rows[k].ad, rows[k].bn, rows[k].bd,
                      rows[k].typed, rows[k].want);
        wait_drained();

        for (int ph = 0; ph < N_PHASE; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            // Long receiver hold-off while the sender keeps offering beats.
            if (ph == 0) hold_req = HOLD_LEN;
            for (int k = 0; k < PHASE_LEN; k++) begin
                act = rau_pkg::t_action'($urandom_range(0, 3));
                bn  = rand_num();
                send_item(act, rand_num(), rand_den(), bn, rand_den(), 0, none);
            end
            // Sender pauses until every result has come back.
            wait_drained();
        end

        repeat (DRAIN_GAP) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: stall at random or for a requested hold-off, check each beat.
    initial begin
        t_fraction want;
        int        hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_beat) begin
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %0d/%0d dz=%0b",
                                 o_res_num, o_res_den, o_div_zero);
                end else begin
                    want = pending_q.pop_front();
                    if (o_res_num !== want.num || o_res_den !== want.den
                            || o_div_zero !== want.dz) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0d dz=%0b, got %0d/%0d dz=%0b",
                                     want.num, want.den, want.dz,
                                     o_res_num, o_res_den, o_div_zero);
                    end
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            quiet = (in_beat || out_beat) ? 0 : quiet + 1;
            if (quiet >= WDOG_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
